// ===== hw/rtl/iheap_pkg.sv =====
// Package for the interval max-heap queue.
// Holds the command and response transfer types and the operation and status codes.
// Depends on nothing.
package iheap_pkg;

    // Operation codes carried in the command transfer.
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // Status codes carried in the response transfer.
    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // One command transfer.
    typedef struct packed {
        logic        func;
        logic [31:0] in_start;
        logic [31:0] in_end;
    } cmd_t;

    // One response transfer.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_start;
        logic [31:0] out_end;
    } rsp_t;

endpackage

// ===== hw/rtl/interval_max_heap_queue.sv =====
// Interval max-heap priority queue: heap memory, sift sequencer and shared comparator.
// Depends on iheap_pkg for the command and response types and codes.
//
// Usage:
// A command transfer is taken at a rising edge where start is high and busy is
// low. cmd.func selects a push of (cmd.in_start, cmd.in_end) or a pop of the
// interval with the highest priority: the greatest length end - start + 1,
// with the smaller start winning a tie. Every command yields exactly one
// response, shown on rsp for the single cycle in which rsp_valid is high;
// the receiver cannot stall it, so it must take it in that cycle.
// busy stays high from the edge after the transfer until the response is
// presented, and a new command may be taken in the cycle that shows it.
// A refused command (push when full, pop when empty) is answered from idle,
// without busy rising. A push climbs: read the parent, load it, compare, then
// move the parent down into the hole or write the new entry there. A pop reads
// the root and the last entry, then sinks: read both children, pick one, compare
// it with the moved entry, then move the child up or write the entry. The steps
// come from the heap memory (one read and one write port, registered read data)
// and the one comparator, which every level of a sift goes through in turn.
// Reset empties the queue at once; memory is not cleared, free slots go unused.
module interval_max_heap_queue
    import iheap_pkg::*;
#(
    parameter int HEAP_DEPTH = 1024,
    parameter int POS_BITS   = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  cmd_t cmd,
    output logic rsp_valid,
    output rsp_t rsp
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    // Sequencer state codes.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_UP_RD   = 4'd1;
    localparam logic [3:0] S_UP_LD   = 4'd2;
    localparam logic [3:0] S_UP_CMP  = 4'd3;
    localparam logic [3:0] S_POP_RD1 = 4'd4;
    localparam logic [3:0] S_POP_RDL = 4'd5;
    localparam logic [3:0] S_POP_LDL = 4'd6;
    localparam logic [3:0] S_DN_RDL  = 4'd7;
    localparam logic [3:0] S_DN_RDR  = 4'd8;
    localparam logic [3:0] S_DN_LDR  = 4'd9;
    localparam logic [3:0] S_DN_CH   = 4'd10;
    localparam logic [3:0] S_DN_CMP  = 4'd11;

    // A stored heap slot.
    typedef struct packed {
        logic [POS_BITS-1:0] start;
        logic [POS_BITS-1:0] stop;
    } slot_t;

    // A slot held in a working register, with its length less one.
    typedef struct packed {
        logic signed [POS_BITS:0] diff;
        logic [POS_BITS-1:0]      start;
        logic [POS_BITS-1:0]      stop;
    } node_t;

    // Attach the signed span to a slot; one subtractor per load.
    function automatic node_t load_node(slot_t s);
        node_t n;
        n.start = s.start;
        n.stop  = s.stop;
        n.diff  = signed'({1'b0, s.stop}) - signed'({1'b0, s.start});
        return n;
    endfunction

    function automatic slot_t to_slot(node_t n);
        slot_t s;
        s.start = n.start;
        s.stop  = n.stop;
        return s;
    endfunction

    // Heap memory and its port signals.
    slot_t mem [HEAP_DEPTH];
    slot_t mem_q;
    logic  mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    slot_t mem_wdata;

    // Control and working registers.
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] c_idx_reg, c_idx_next;
    node_t cur_reg, cur_next;
    node_t a_reg, a_next;
    node_t b_reg, b_next;
    slot_t top_reg, top_next;
    logic  rsp_valid_reg, rsp_valid_next;
    rsp_t  rsp_reg, rsp_next;

    // Shared comparator operands and result.
    node_t cmp_x, cmp_y;
    logic  cmp_gt;

    logic [CW:0] lc;
    logic [CW:0] rc;
    logic [CW:0] parent;
    slot_t in_slot;

    assign lc     = {n_reg, 1'b0};
    assign rc     = {n_reg, 1'b1};
    assign parent = (CW + 1)'(n_reg >> 1);

    assign in_slot.start = POS_BITS'(cmd.in_start);
    assign in_slot.stop  = POS_BITS'(cmd.in_end);

    // Shared comparator: true when cmp_x strictly outranks cmp_y.
    always_comb
    begin
        unique case (state_reg)
            S_UP_CMP:
            begin
                cmp_x = cur_reg;
                cmp_y = a_reg;
            end
            S_DN_CH:
            begin
                cmp_x = a_reg;
                cmp_y = b_reg;
            end
            default:
            begin
                cmp_x = a_reg;
                cmp_y = cur_reg;
            end
        endcase
        if (cmp_x.diff == cmp_y.diff)
        begin
            cmp_gt = cmp_x.start < cmp_y.start;
        end
        else
        begin
            cmp_gt = cmp_x.diff > cmp_y.diff;
        end
    end

    // Sequencer: sift up for a push, sift down for a pop, hole method.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        n_next         = n_reg;
        c_idx_next     = c_idx_reg;
        cur_next       = cur_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        top_next       = top_reg;
        rsp_valid_next = 1'b0;
        rsp_next       = rsp_reg;
        mem_we         = 1'b0;
        mem_waddr      = AW'(n_reg - 1'b1);
        mem_wdata      = to_slot(cur_reg);
        mem_raddr      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.func == FUNC_PUSH)
                    begin
                        if (count_reg == CW'(HEAP_DEPTH))
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '{status: STATUS_FULL, out_start: '0, out_end: '0};
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            n_next     = count_reg + 1'b1;
                            cur_next   = load_node(in_slot);
                            state_next = S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            rsp_valid_next = 1'b1;
                            rsp_next       = '{status: STATUS_EMPTY, out_start: '0, out_end: '0};
                        end
                        else
                        begin
                            state_next = S_POP_RD1;
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                if (n_reg == CW'(1))
                begin
                    mem_we         = 1'b1;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: STATUS_DONE, out_start: '0, out_end: '0};
                    state_next     = S_IDLE;
                end
                else
                begin
                    mem_raddr  = AW'(parent - 1'b1);
                    state_next = S_UP_LD;
                end
            end
            S_UP_LD:
            begin
                a_next     = load_node(mem_q);
                state_next = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_gt)
                begin
                    // Parent moves down into the hole; the hole climbs.
                    mem_wdata  = to_slot(a_reg);
                    n_next     = CW'(parent);
                    state_next = S_UP_RD;
                end
                else
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: STATUS_DONE, out_start: '0, out_end: '0};
                    state_next     = S_IDLE;
                end
            end
            S_POP_RD1:
            begin
                mem_raddr  = '0;
                state_next = S_POP_RDL;
            end
            S_POP_RDL:
            begin
                top_next   = mem_q;
                mem_raddr  = AW'(count_reg - 1'b1);
                state_next = S_POP_LDL;
            end
            S_POP_LDL:
            begin
                cur_next   = load_node(mem_q);
                count_next = count_reg - 1'b1;
                n_next     = CW'(1);
                state_next = S_DN_RDL;
            end
            S_DN_RDL:
            begin
                if (lc > {1'b0, count_reg})
                begin
                    mem_we         = 1'b1;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: STATUS_DONE,
                                       out_start: 32'(top_reg.start),
                                       out_end: 32'(top_reg.stop)};
                    state_next     = S_IDLE;
                end
                else
                begin
                    mem_raddr  = AW'(lc - 1'b1);
                    state_next = S_DN_RDR;
                end
            end
            S_DN_RDR:
            begin
                a_next     = load_node(mem_q);
                mem_raddr  = AW'(rc - 1'b1);
                state_next = S_DN_LDR;
            end
            S_DN_LDR:
            begin
                b_next     = load_node(mem_q);
                state_next = S_DN_CH;
            end
            S_DN_CH:
            begin
                // A lone left child is taken as is; otherwise left only if strictly higher.
                if (lc == {1'b0, count_reg} || cmp_gt)
                begin
                    c_idx_next = CW'(lc);
                end
                else
                begin
                    a_next     = b_reg;
                    c_idx_next = CW'(rc);
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                mem_we = 1'b1;
                if (cmp_gt)
                begin
                    // Child moves up into the hole; the hole sinks.
                    mem_wdata  = to_slot(a_reg);
                    n_next     = c_idx_reg;
                    state_next = S_DN_RDL;
                end
                else
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{status: STATUS_DONE,
                                       out_start: 32'(top_reg.start),
                                       out_end: 32'(top_reg.stop)};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Heap memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q <= mem[mem_raddr];
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Working and response payload registers.
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        c_idx_reg <= c_idx_next;
        cur_reg   <= cur_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        top_reg   <= top_next;
        rsp_reg   <= rsp_next;
    end

    assign busy      = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // An accepted command either answers at once or keeps the block busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || rsp_valid)
        else $error("accepted command neither answered nor in progress");

    // A full refusal is only given while the heap is at capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STATUS_FULL |-> count_reg == CW'(HEAP_DEPTH))
        else $error("full refusal with free slots");

    // A push into a heap with room grows the entry count by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd.func == FUNC_PUSH && count_reg != CW'(HEAP_DEPTH)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("push did not grow entry count");

    // Heap writes stay inside the occupied part of the memory, or the heap is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW + 1)'(mem_waddr) < (CW + 1)'(count_reg) || count_reg == '0)
        else $error("heap write beyond occupied slots");

endmodule

// ===== sim/interval_max_heap_queue_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the interval max-heap queue.
// Uses a software heap predictor and a response scoreboard; depends on iheap_pkg.
module interval_max_heap_queue_tb;
    import iheap_pkg::*;

    localparam int DEPTH = 1024;
    localparam int MAX_SHOWN = 10;

    // One row of the directed table. A pinned row carries its response
    // literally; the others take the predictor's answer.
    typedef struct {
        cmd_t c;
        bit   pinned;
        rsp_t value;
    } dir_row_t;

    typedef struct {
        bit   pinned;
        rsp_t value;
    } pin_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    cmd_t cmd;
    logic rsp_valid;
    rsp_t rsp;

    // Predictor state: 1-based heap of intervals and its occupancy.
    logic [31:0] heap_start [1:DEPTH];
    logic [31:0] heap_end   [1:DEPTH];
    int          heap_count;

    rsp_t     expected_rsp[$];
    pin_t     pinned_rsp[$];
    dir_row_t dir_rows[$];

    int  errors;
    int  fill_level;
    int  peak_level;
    int  n_push;
    int  n_pop;
    int  n_full;
    int  n_empty;
    bit  steady_sender;

    interval_max_heap_queue #(
        .HEAP_DEPTH(DEPTH),
        .POS_BITS  (32)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp      (rsp)
    );

    // Free-running clock, 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Global watchdog.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Priority order: longer interval first, smaller start breaks a tie.
    function automatic bit ranks_above(int a, int b);
        longint len_a;
        longint len_b;
        len_a = longint'(heap_end[a]) - longint'(heap_start[a]) + 1;
        len_b = longint'(heap_end[b]) - longint'(heap_start[b]) + 1;
        if (len_a == len_b)
            return heap_start[a] < heap_start[b];
        return len_a > len_b;
    endfunction

    function automatic void swap_nodes(int a, int b);
        logic [31:0] t_start;
        logic [31:0] t_end;
        t_start = heap_start[a];
        t_end = heap_end[a];
        heap_start[a] = heap_start[b];
        heap_end[a] = heap_end[b];
        heap_start[b] = t_start;
        heap_end[b] = t_end;
    endfunction

    // Apply one command to the predicted heap and return its response.
    function automatic rsp_t heap_response(cmd_t c);
        rsp_t r;
        int   n;
        int   child;
        bit   settled;
        r = '0;
        if (c.func == FUNC_PUSH)
        begin
            if (heap_count >= DEPTH)
            begin
                r.status = STATUS_FULL;
            end
            else
            begin
                heap_count++;
                heap_start[heap_count] = c.in_start;
                heap_end[heap_count] = c.in_end;
                n = heap_count;
                while (n > 1 && ranks_above(n, n / 2))
                begin
                    swap_nodes(n, n / 2);
                    n = n / 2;
                end
                r.status = STATUS_DONE;
            end
        end
        else
        begin
            if (heap_count == 0)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                r.status = STATUS_DONE;
                r.out_start = heap_start[1];
                r.out_end = heap_end[1];
                heap_start[1] = heap_start[heap_count];
                heap_end[1] = heap_end[heap_count];
                heap_count--;
                n = 1;
                settled = 1'b0;
                while (!settled && 2 * n <= heap_count)
                begin
                    if (2 * n == heap_count)
                        child = 2 * n;
                    else
                        child = ranks_above(2 * n, 2 * n + 1) ? 2 * n : 2 * n + 1;
                    if (!ranks_above(child, n))
                    begin
                        settled = 1'b1;
                    end
                    else
                    begin
                        swap_nodes(child, n);
                        n = child;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
        errors++;
        if (errors <= MAX_SHOWN)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, field, want, got);
    endfunction

    // Scoreboard: check each response, then record the command taken at this edge.
    always @(posedge clk)
    begin
        rsp_t want;
        pin_t pin;
        rsp_t predicted;
        if (rst_n && rsp_valid)
        begin
            if (expected_rsp.size() == 0)
            begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t: response with none outstanding: %h", $realtime, rsp);
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.status !== want.status)
                    flag_mismatch("status", 32'(want.status), 32'(rsp.status));
                if (rsp.out_start !== want.out_start)
                    flag_mismatch("out_start", want.out_start, rsp.out_start);
                if (rsp.out_end !== want.out_end)
                    flag_mismatch("out_end", want.out_end, rsp.out_end);
            end
        end
        if (rst_n && start && !busy)
        begin
            pin = pinned_rsp.pop_front();
            predicted = heap_response(cmd);
            expected_rsp.push_back(pin.pinned ? pin.value : predicted);
            if (heap_count > peak_level)
                peak_level = heap_count;
            case (predicted.status)
                STATUS_FULL:  n_full++;
                STATUS_EMPTY: n_empty++;
                default:
                begin
                    if (cmd.func == FUNC_PUSH)
                        n_push++;
                    else
                        n_pop++;
                end
            endcase
        end
    end

    // Random idle before a transfer, unless the sender is in its steady stretch.
    function automatic int idle_cycles();
        if (steady_sender || $urandom_range(0, 99) >= 36)
            return 0;
        return $urandom_range(1, 4);
    endfunction

    // Present one command at the falling edge and hold it until it is taken.
    task automatic issue(input cmd_t c, input bit pinned, input rsp_t value);
        int   gap;
        pin_t pin;
        gap = idle_cycles();
        if (gap > 0)
        begin
            start = 1'b0;
            cmd = {1'($urandom), $urandom, $urandom};
            repeat (gap) @(negedge clk);
        end
        pin.pinned = pinned;
        pin.value = value;
        pinned_rsp.push_back(pin);
        start = 1'b1;
        cmd = c;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (c.func == FUNC_PUSH && fill_level < DEPTH)
            fill_level++;
        else if (c.func == FUNC_POP && fill_level > 0)
            fill_level--;
    endtask

    // Random interval: clustered short spans for ties, full range, extremes, wrap.
    function automatic cmd_t random_cmd(bit is_push);
        cmd_t c;
        c.func = is_push ? FUNC_PUSH : FUNC_POP;
        c.in_start = $urandom;
        c.in_end = $urandom;
        if (is_push)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    c.in_start = $urandom_range(0, 15);
                    c.in_end = c.in_start + $urandom_range(0, 7) - 2;
                end
                1: ;
                2:
                begin
                    if ($urandom_range(0, 1))
                        c.in_start = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                    if ($urandom_range(0, 1))
                        c.in_end = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                end
                default:
                begin
                    c.in_end = c.in_start + $urandom_range(0, 40);
                end
            endcase
        end
        return c;
    endfunction

    task automatic send_random(input int push_pct);
        issue(random_cmd($urandom_range(0, 99) < push_pct), 1'b0, '0);
    endtask

    // Hold the sender off until every outstanding response has arrived.
    task automatic wait_quiet();
        start = 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic add_row(input logic func, input logic [31:0] s, input logic [31:0] e,
                           input bit pinned, input logic [1:0] status,
                           input logic [31:0] o_start, input logic [31:0] o_end);
        dir_row_t row;
        row.c = '{func: func, in_start: s, in_end: e};
        row.pinned = pinned;
        row.value = '{status: status, out_start: o_start, out_end: o_end};
        dir_rows.push_back(row);
    endtask

    initial
    begin
        int i;
        int spin;
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        errors = 0;
        heap_count = 0;
        fill_level = 0;
        peak_level = 0;
        n_push = 0;
        n_pop = 0;
        n_full = 0;
        n_empty = 0;
        steady_sender = 1'b0;

        // Directed table: empty pop, extreme spans, equal-length ties, end before start.
        add_row(FUNC_POP,  32'h0,         32'h0,         1'b1, STATUS_EMPTY, 0, 0);
        add_row(FUNC_PUSH, 32'h0,         32'hFFFF_FFFF, 1'b1, STATUS_DONE, 0, 0);
        add_row(FUNC_PUSH, 32'hFFFF_FFFF, 32'h0,         1'b1, STATUS_DONE, 0, 0);
        add_row(FUNC_PUSH, 32'd5,         32'd5,         1'b1, STATUS_DONE, 0, 0);
        add_row(FUNC_PUSH, 32'd3,         32'd3,         1'b1, STATUS_DONE, 0, 0);
        add_row(FUNC_PUSH, 32'd10,        32'd12,        1'b1, STATUS_DONE, 0, 0);
        add_row(FUNC_PUSH, 32'd20,        32'd22,        1'b1, STATUS_DONE, 0, 0);
        add_row(FUNC_PUSH, 32'd7,         32'd7,         1'b1, STATUS_DONE, 0, 0);
        add_row(FUNC_PUSH, 32'd0,         32'd0,         1'b1, STATUS_DONE, 0, 0);
        add_row(FUNC_PUSH, 32'd5,         32'd5,         1'b1, STATUS_DONE, 0, 0);
        add_row(FUNC_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STATUS_DONE, 0, 0);
        add_row(FUNC_POP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, STATUS_DONE, 0, 32'hFFFF_FFFF);
        for (i = 0; i < 8; i++)
            add_row(FUNC_POP, $urandom, $urandom, 1'b0, STATUS_DONE, 0, 0);
        add_row(FUNC_POP,  32'h0,         32'h0,         1'b1, STATUS_DONE, 32'hFFFF_FFFF, 0);
        add_row(FUNC_POP,  32'h0,         32'h0,         1'b1, STATUS_EMPTY, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[k])
            issue(dir_rows[k].c, dir_rows[k].pinned, dir_rows[k].value);
        wait_quiet();

        // Mixed traffic that lets the heap grow, with random idling.
        for (i = 0; i < 300; i++)
            send_random(60);
        wait_quiet();

        // Back-to-back transfers, no idling at all.
        steady_sender = 1'b1;
        for (i = 0; i < 150; i++)
            send_random(50);
        steady_sender = 1'b0;

        // Drain to empty, then pop past the bottom.
        while (fill_level > 0)
            send_random(10);
        for (i = 0; i < 3; i++)
            send_random(0);

        // Short-lived heap that keeps hitting empty.
        for (i = 0; i < 100; i++)
            send_random(45);
        start = 1'b0;

        // Let the last responses land, with a bound.
        spin = 0;
        while (expected_rsp.size() != 0 && spin < 2000)
        begin
            @(posedge clk);
            spin++;
        end
        repeat (60) @(posedge clk);
        if (expected_rsp.size() != 0)
        begin
            errors += expected_rsp.size();
            $display("%0d responses never arrived", expected_rsp.size());
        end

        $display("Covered %0d pushes and %0d pops, %0d refused when full, %0d when empty.",
                 n_push, n_pop, n_full, n_empty);
        $display("Heap occupancy peaked at %0d of %0d entries.", peak_level, DEPTH);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
